[hdl/uabf_pkg.sv]
package uabf_pkg;

   // Sample store geometry (power of two, so the pointers wrap on their own)
   localparam int FifoDepth = 8192;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = PtrW + 1;

   // Default start threshold terms
   localparam int FramesPerPeriod = 512;
   localparam int PrimePeriods    = 4;
   localparam int PrimeFrames     = PrimePeriods * FramesPerPeriod;
   localparam int RateRound       = 31;
   localparam int RateShift       = 5;
   localparam int RateW           = 16;

   // Queue between the front and the back
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = QPtrW + 1;

   typedef enum logic [1:0] {
      CSR_UPSAMPLE = 2'd0,
      CSR_RATE     = 2'd1,
      CSR_STARTUP  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_PULL  = 2'd1,
      OP_FLUSH = 2'd2
   } opcode_type;

   // What the back does with the held sample for one transfer
   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,   // output silence, keep held sample
      KIND_LOAD  = 2'd1,   // convert the fetched byte, hold and output it
      KIND_HOLD  = 2'd2,   // repeat the held sample
      KIND_CLEAR = 2'd3    // clear the held sample, output silence
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic             accepted;
      logic             underrun;
      logic             playing;
      logic [CntW-1:0]  fill_level;
      logic [7:0]       data;
   } entry_type;

   // Prime frame count divided by the effective upsample factor
   function automatic logic [CntW-1:0] prime_share(input logic [2:0] factor);
      logic [CntW-1:0] share;
      case (factor)
         3'd2:    share = CntW'(PrimeFrames / 2);
         3'd3:    share = CntW'(PrimeFrames / 3);
         3'd4:    share = CntW'(PrimeFrames / 4);
         3'd5:    share = CntW'(PrimeFrames / 5);
         3'd6:    share = CntW'(PrimeFrames / 6);
         3'd7:    share = CntW'(PrimeFrames / 7);
         default: share = CntW'(PrimeFrames);
      endcase
      return share;
   endfunction

endpackage

[hdl/uabf_front.sv]
module uabf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [1:0]                  csr_index,
   input  logic [uabf_pkg::RateW-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [7:0]                  req_byte_value,
   input  logic                        req_end_of_write,
   input  logic [uabf_pkg::QCntW-1:0]  q_level,
   output logic                        ent_valid,
   output uabf_pkg::entry_type         ent
);

   logic [2:0]                  factor_ff;
   logic [uabf_pkg::RateW-1:0]  rate_ff;
   logic [uabf_pkg::CntW-1:0]   startup_ff;

   logic [uabf_pkg::PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [uabf_pkg::PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [uabf_pkg::CntW-1:0]   count_ff, count_in;
   logic [2:0]                  repeats_ff, repeats_in;
   logic                        started_ff, started_in;
   logic                        s1_valid_ff;
   uabf_pkg::entry_type         s1_ent_ff, s1_ent_in;
   logic [7:0]                  rd_data_ff;
   logic [7:0]                  store_mem [uabf_pkg::FifoDepth];

   logic [uabf_pkg::QCntW:0]    occupancy;
   logic                        accept;
   logic                        write_en;
   logic [2:0]                  eff_factor;
   logic [2:0]                  repeat_base;
   logic [uabf_pkg::RateW:0]    rate_sum;
   logic [uabf_pkg::CntW-1:0]   default_thr;
   logic [uabf_pkg::CntW-1:0]   threshold;

   // Admit a transfer only while the read stage and the queue have room
   assign occupancy = {1'b0, q_level} + {{uabf_pkg::QCntW{1'b0}}, s1_valid_ff};
   assign req_ready = occupancy < (uabf_pkg::QCntW + 1)'(uabf_pkg::QueueDepth);
   assign accept    = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff  <= 3'd4;
         rate_ff    <= uabf_pkg::RateW'(11025);
         startup_ff <= '0;
      end else if (csr_write_en) begin
         case (uabf_pkg::csr_index_type'(csr_index))
            uabf_pkg::CSR_UPSAMPLE: factor_ff  <= csr_wdata[2:0];
            uabf_pkg::CSR_RATE:     rate_ff    <= csr_wdata;
            uabf_pkg::CSR_STARTUP:  startup_ff <= csr_wdata[uabf_pkg::CntW-1:0];
            default: ;
         endcase
      end
   end

   // Start threshold: explicit count, or prime share plus rounded rate/32
   assign eff_factor  = (factor_ff == 3'd0) ? 3'd1 : factor_ff;
   assign rate_sum    = {1'b0, rate_ff} + (uabf_pkg::RateW + 1)'(uabf_pkg::RateRound);
   assign default_thr = uabf_pkg::prime_share(factor_ff)
                      + uabf_pkg::CntW'(rate_sum[uabf_pkg::RateW:uabf_pkg::RateShift]);
   assign threshold   = (startup_ff != '0) ? startup_ff : default_thr;

   // Classify the transfer and advance the FIFO bookkeeping
   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      count_in    = count_ff;
      repeats_in  = repeats_ff;
      started_in  = started_ff;
      write_en    = 1'b0;
      repeat_base = repeats_ff;
      s1_ent_in   = '0;
      s1_ent_in.kind = uabf_pkg::KIND_PASS;
      if (accept) begin
         case (uabf_pkg::opcode_type'(req_opcode))
            uabf_pkg::OP_PUSH: begin
               if (count_ff < uabf_pkg::CntW'(uabf_pkg::FifoDepth)) begin
                  write_en           = 1'b1;
                  wr_ptr_in          = wr_ptr_ff + 1'b1;
                  count_in           = count_ff + 1'b1;
                  s1_ent_in.accepted = 1'b1;
               end
               if (req_end_of_write && !started_ff && count_in >= threshold) begin
                  started_in = 1'b1;
               end
            end
            uabf_pkg::OP_PULL: begin
               if (repeats_ff == 3'd0) begin
                  repeat_base = eff_factor;
                  if (count_ff != '0) begin
                     s1_ent_in.kind = uabf_pkg::KIND_LOAD;
                     rd_ptr_in      = rd_ptr_ff + 1'b1;
                     count_in       = count_ff - 1'b1;
                  end else begin
                     s1_ent_in.kind     = uabf_pkg::KIND_CLEAR;
                     s1_ent_in.underrun = 1'b1;
                  end
               end else begin
                  s1_ent_in.kind = uabf_pkg::KIND_HOLD;
               end
               repeats_in = repeat_base - 3'd1;
            end
            uabf_pkg::OP_FLUSH: begin
               s1_ent_in.kind = uabf_pkg::KIND_CLEAR;
               rd_ptr_in      = '0;
               wr_ptr_in      = '0;
               count_in       = '0;
               repeats_in     = 3'd0;
               started_in     = 1'b0;
            end
            default: ;
         endcase
      end
      s1_ent_in.playing    = started_in;
      s1_ent_in.fill_level = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= '0;
         repeats_ff  <= 3'd0;
         started_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         count_ff    <= count_in;
         repeats_ff  <= repeats_in;
         started_ff  <= started_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ent_ff <= s1_ent_in;
   end

   // Sample store: one write port, one registered read at the read pointer
   always_ff @(posedge clock) begin
      if (write_en) begin
         store_mem[wr_ptr_ff] <= req_byte_value;
      end
      rd_data_ff <= store_mem[rd_ptr_ff];
   end

   // Join the fetched byte to the classified transfer
   always_comb begin
      ent      = s1_ent_ff;
      ent.data = rd_data_ff;
   end
   assign ent_valid = s1_valid_ff;

endmodule

[hdl/uabf_queue.sv]
module uabf_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  uabf_pkg::entry_type         push_ent,
   input  logic                        pop,
   output logic                        head_valid,
   output uabf_pkg::entry_type         head_ent,
   output logic [uabf_pkg::QCntW-1:0]  level
);

   uabf_pkg::entry_type               slot_ff [uabf_pkg::QueueDepth];
   logic [uabf_pkg::QPtrW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [uabf_pkg::QCntW-1:0]        level_ff, level_in;

   // Track fill; the front never pushes into a full queue
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_ent;
      end
   end

   assign head_ent   = slot_ff[rd_ptr_ff];
   assign head_valid = level_ff != '0;
   assign level      = level_ff;

endmodule

[hdl/uabf_back.sv]
module uabf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  uabf_pkg::entry_type         head_ent,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_sample_out,
   output logic                        rsp_accepted,
   output logic                        rsp_underrun,
   output logic                        rsp_playing,
   output logic [uabf_pkg::CntW-1:0]   rsp_fill_level
);

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [15:0]                  held_ff, held_in;
   logic [15:0]                  sample_in;
   logic [15:0]                  sample_ff;
   uabf_pkg::entry_type          out_ent_ff;

   // Take the next transfer whenever the output register is free or drains
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   // Convert offset-binary byte to signed 16-bit and apply hold
   always_comb begin
      held_in   = held_ff;
      sample_in = 16'd0;
      case (head_ent.kind)
         uabf_pkg::KIND_LOAD: begin
            held_in   = {head_ent.data ^ 8'h80, 8'h00};
            sample_in = held_in;
         end
         uabf_pkg::KIND_HOLD: begin
            sample_in = held_ff;
         end
         uabf_pkg::KIND_CLEAR: begin
            held_in = 16'd0;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= 16'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            held_ff <= held_in;
         end
      end
   end

   // Output payload holds while stalled
   always_ff @(posedge clock) begin
      if (pop) begin
         sample_ff  <= sample_in;
         out_ent_ff <= head_ent;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = $signed(sample_ff);
   assign rsp_accepted   = out_ent_ff.accepted;
   assign rsp_underrun   = out_ent_ff.underrun;
   assign rsp_playing    = out_ent_ff.playing;
   assign rsp_fill_level = out_ent_ff.fill_level;

endmodule

[hdl/upsampling_audio_byte_fifo_core.sv]
// Zero-order-hold upsampling byte FIFO. Push stores an unsigned audio byte in an
// 8192-entry store, pull returns one signed 16-bit frame that repeats each byte
// upsample_factor times, flush empties everything; every request gives exactly
// one response, in order. The block takes one request per cycle while req_ready
// is high. The front updates the FIFO bookkeeping and reads the single-port-read
// store in the accept cycle, the fetched byte joins its registered request and enters a
// four-entry queue, and the back turns it into the response register. req_ready
// drops only when four requests sit between front and response because
// rsp_ready held them back. The store is not cleared after reset; no byte is
// read before it was pushed. Write the configuration registers only while no
// request is in flight.
module upsampling_audio_byte_fifo_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [1:0]                  csr_index,
   input  logic [uabf_pkg::RateW-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_opcode,
   input  logic [7:0]                  req_byte_value,
   input  logic                        req_end_of_write,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [15:0]          rsp_sample_out,
   output logic                        rsp_accepted,
   output logic                        rsp_underrun,
   output logic                        rsp_playing,
   output logic [uabf_pkg::CntW-1:0]   rsp_fill_level
);

   logic                        ent_valid;
   uabf_pkg::entry_type         ent;
   logic                        pop;
   logic                        head_valid;
   uabf_pkg::entry_type         head_ent;
   logic [uabf_pkg::QCntW-1:0]  q_level;

   uabf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_byte_value   (req_byte_value),
      .req_end_of_write (req_end_of_write),
      .q_level          (q_level),
      .ent_valid        (ent_valid),
      .ent              (ent)
   );

   uabf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ent_valid),
      .push_ent   (ent),
      .pop        (pop),
      .head_valid (head_valid),
      .head_ent   (head_ent),
      .level      (q_level)
   );

   uabf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_ent       (head_ent),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_accepted   (rsp_accepted),
      .rsp_underrun   (rsp_underrun),
      .rsp_playing    (rsp_playing),
      .rsp_fill_level (rsp_fill_level)
   );

endmodule

[hdl/uabf_checker.sv]
module uabf_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [15:0]          rsp_sample_out,
   input  logic                        rsp_accepted,
   input  logic                        rsp_underrun,
   input  logic                        rsp_playing,
   input  logic [uabf_pkg::CntW-1:0]   rsp_fill_level
);

   // Stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_accepted) && $stable(rsp_underrun)
         && $stable(rsp_playing) && $stable(rsp_fill_level))
      else $error("response changed while stalled");

   // Underrun always plays silence
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_underrun |-> rsp_sample_out == 16'sd0)
      else $error("underrun frame not silent");

   // A stored push is never a pull: no frame and no underrun
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_underrun && rsp_sample_out == 16'sd0)
      else $error("accepted push carries frame data");

   // Fill level never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fill_level <= uabf_pkg::CntW'(uabf_pkg::FifoDepth))
      else $error("fill level beyond store depth");

endmodule

bind upsampling_audio_byte_fifo_core uabf_checker u_checker (.*);

[dv/tb_top.sv]
module tb_top;

   localparam logic [1:0] OpUnused  = 2'd3;
   localparam logic [1:0] CsrUnused = 2'd3;
   localparam int         IdlePct   = 12;

   typedef struct {
      logic [15:0]               sample;
      logic                      accepted;
      logic                      underrun;
      logic                      playing;
      logic [uabf_pkg::CntW-1:0] fill;
   } frame_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          csr_write_en     = 1'b0;
   logic [1:0]                    csr_index        = uabf_pkg::CSR_UPSAMPLE;
   logic [uabf_pkg::RateW-1:0]    csr_wdata        = '0;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_opcode       = uabf_pkg::OP_PUSH;
   logic [7:0]                    req_byte_value   = '0;
   logic                          req_end_of_write = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic signed [15:0]            rsp_sample_out;
   logic                          rsp_accepted;
   logic                          rsp_underrun;
   logic                          rsp_playing;
   logic [uabf_pkg::CntW-1:0]     rsp_fill_level;

   // Shadow of the FIFO and its registers
   logic [7:0]                    zoh_store [uabf_pkg::FifoDepth];
   logic [uabf_pkg::PtrW-1:0]     rd_ptr      = '0;
   logic [uabf_pkg::PtrW-1:0]     wr_ptr      = '0;
   int                            level       = 0;
   logic [15:0]                   held        = '0;
   logic [2:0]                    repeats     = '0;
   logic                          play        = 1'b0;
   logic [2:0]                    reg_factor  = 3'd4;
   logic [15:0]                   reg_rate    = 16'd11025;
   logic [13:0]                   reg_startup = '0;

   frame_type           frame_queue [$];
   int                  mismatches  = 0;
   int                  hold_cycles = 0;
   logic                calm        = 1'b0;

   upsampling_audio_byte_fifo_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_byte_value   (req_byte_value),
      .req_end_of_write (req_end_of_write),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_accepted     (rsp_accepted),
      .rsp_underrun     (rsp_underrun),
      .rsp_playing      (rsp_playing),
      .rsp_fill_level   (rsp_fill_level)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // Advance the shadow FIFO by one request and produce the frame it returns
   task automatic advance_fifo_model(input logic [1:0] op, input logic [7:0] b,
                                     input logic eow, output frame_type f);
      int k;
      int thr;
      k = (reg_factor == 3'd0) ? 1 : int'(reg_factor);
      f.sample   = '0;
      f.accepted = 1'b0;
      f.underrun = 1'b0;
      case (op)
         uabf_pkg::OP_PUSH: begin
            if (level < uabf_pkg::FifoDepth) begin
               zoh_store[wr_ptr] = b;
               wr_ptr = wr_ptr + 1'b1;
               level = level + 1;
               f.accepted = 1'b1;
            end
            thr = (reg_startup != 0) ? int'(reg_startup)
                  : uabf_pkg::PrimeFrames / k + (int'(reg_rate) + uabf_pkg::RateRound) / 32;
            if (eow && !play && level >= thr) play = 1'b1;
         end
         uabf_pkg::OP_PULL: begin
            // Fetch a new byte only once the held one has been repeated enough
            if (repeats == 3'd0) begin
               if (level != 0) begin
                  held = {zoh_store[rd_ptr] ^ 8'h80, 8'h00};
                  rd_ptr = rd_ptr + 1'b1;
                  level = level - 1;
               end else begin
                  held = '0;
                  f.underrun = 1'b1;
               end
               repeats = 3'(k);
            end
            f.sample = held;
            repeats = repeats - 3'd1;
         end
         uabf_pkg::OP_FLUSH: begin
            rd_ptr  = '0;
            wr_ptr  = '0;
            level   = 0;
            held    = '0;
            repeats = '0;
            play    = 1'b0;
         end
         default: ;
      endcase
      f.playing = play;
      f.fill    = uabf_pkg::CntW'(level);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Check each response transfer, then record each request transfer and register write
   always @(posedge clock) begin
      frame_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (frame_queue.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual sample %0h fill %0d",
                        $time, rsp_sample_out, rsp_fill_level);
               mismatches++;
            end else begin
               want = frame_queue.pop_front();
               check_field("sample_out", want.sample, rsp_sample_out);
               check_field("accepted", 16'(want.accepted), 16'(rsp_accepted));
               check_field("underrun", 16'(want.underrun), 16'(rsp_underrun));
               check_field("playing", 16'(want.playing), 16'(rsp_playing));
               check_field("fill_level", 16'(want.fill), 16'(rsp_fill_level));
            end
         end
         if (req_valid && req_ready) begin
            advance_fifo_model(req_opcode, req_byte_value, req_end_of_write, want);
            frame_queue.push_back(want);
         end
         if (csr_write_en) begin
            case (csr_index)
               uabf_pkg::CSR_UPSAMPLE: reg_factor  = csr_wdata[2:0];
               uabf_pkg::CSR_RATE:     reg_rate    = csr_wdata;
               uabf_pkg::CSR_STARTUP:  reg_startup = csr_wdata[13:0];
               default: ;
            endcase
         end
      end
   end

   // Response side: random idling, or a counted hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
         end
      end
   end

   initial begin
      #15_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one request and hold it until its transfer
   task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic eow);
      if (!calm && $urandom_range(0, 99) < IdlePct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_byte_value   <= b;
      req_end_of_write <= eow;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (frame_queue.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write all three registers, junk in the unused upper bits, optionally the unused index
   task automatic write_registers(input logic [2:0] factor, input logic [15:0] rate,
                                  input logic [13:0] startup, input logic poke_unused);
      logic [1:0]  idx  [4];
      logic [15:0] data [4];
      int          n;
      wait_idle();
      idx[0]  = uabf_pkg::CSR_UPSAMPLE;
      data[0] = {13'($urandom), factor};
      idx[1]  = uabf_pkg::CSR_RATE;
      data[1] = rate;
      idx[2]  = uabf_pkg::CSR_STARTUP;
      data[2] = {2'($urandom), startup};
      idx[3]  = CsrUnused;
      data[3] = 16'($urandom);
      n = poke_unused ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_wdata    <= data[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // Silence on empty, byte extremes, hold repeats, flush mid-hold, unused opcode
   task automatic test_empty_and_extremes();
      repeat (5) send_item(uabf_pkg::OP_PULL, 8'hA5, 1'b1);
      send_item(uabf_pkg::OP_PUSH, 8'h00, 1'b0);
      send_item(uabf_pkg::OP_PUSH, 8'hFF, 1'b0);
      send_item(uabf_pkg::OP_PUSH, 8'h80, 1'b1);
      send_item(uabf_pkg::OP_PUSH, 8'h7F, 1'b0);
      repeat (9) send_item(uabf_pkg::OP_PULL, 8'h5A, 1'b0);
      send_item(uabf_pkg::OP_FLUSH, 8'hFF, 1'b1);
      send_item(uabf_pkg::OP_PULL, 8'h00, 1'b0);
      send_item(OpUnused, 8'hFF, 1'b1);
      send_item(uabf_pkg::OP_PULL, 8'h00, 1'b0);
   endtask

   // Explicit start count, zero factor, write to the unused index
   task automatic test_start_threshold();
      write_registers(3'd0, 16'd11025, 14'd3, 1'b1);
      send_item(uabf_pkg::OP_PUSH, 8'h12, 1'b0);
      send_item(uabf_pkg::OP_PUSH, 8'hC3, 1'b1);
      send_item(uabf_pkg::OP_PUSH, 8'h40, 1'b0);
      send_item(uabf_pkg::OP_PUSH, 8'h81, 1'b1);
      send_item(uabf_pkg::OP_PUSH, 8'h01, 1'b1);
      repeat (3) send_item(uabf_pkg::OP_PULL, 8'h00, 1'b1);
      send_item(uabf_pkg::OP_FLUSH, 8'h00, 1'b0);
      send_item(uabf_pkg::OP_PULL, 8'h00, 1'b0);
   endtask

   // Largest default threshold, a gapless stream of pushes, then drain past empty
   task automatic test_calm_stream();
      write_registers(3'd1, 16'hFFFF, 14'd0, 1'b0);
      calm = 1'b1;
      send_item(uabf_pkg::OP_FLUSH, 8'h00, 1'b0);
      for (int i = 0; i < 70; i++)
         send_item(uabf_pkg::OP_PUSH, 8'($urandom), (i % 16) == 15);
      repeat (73) send_item(uabf_pkg::OP_PULL, 8'($urandom), 1'($urandom));
      calm = 1'b0;
   endtask

   // Hold the response side off long enough that the block stalls its input
   task automatic test_backpressure();
      write_registers(3'd2, 16'd22050, 14'd5, 1'b0);
      send_item(uabf_pkg::OP_FLUSH, 8'h00, 1'b0);
      hold_cycles = 80;
      for (int i = 0; i < 40; i++)
         send_item(($urandom_range(0, 2) == 0) ? uabf_pkg::OP_PULL : uabf_pkg::OP_PUSH,
                   8'($urandom), 1'($urandom));
   endtask

   // Several register settings, each with mostly well-formed writes followed by pulls
   task automatic test_random_mix();
      logic [2:0]  factor;
      logic [15:0] rate;
      logic [13:0] startup;
      int          counted;
      int          pick;
      int          len;
      for (int s = 0; s < 8; s++) begin
         case (s)
            0: begin factor = 3'd1; rate = 16'd44100; startup = 14'd0; end
            1: begin factor = 3'd7; rate = 16'd0; startup = 14'd0; end
            2: begin factor = 3'd0; rate = 16'd11025; startup = 14'd1; end
            3: begin factor = 3'd4; rate = 16'($urandom); startup = 14'h3FFF; end
            4: begin factor = 3'd5; rate = 16'($urandom); startup = 14'd8192; end
            default: begin
               factor  = 3'($urandom_range(0, 7));
               rate    = 16'($urandom);
               startup = 14'($urandom_range(0, 40));
            end
         endcase
         write_registers(factor, rate, startup, s == 5);
         counted = 0;
         while (counted < 130) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               len = $urandom_range(1, 24);
               for (int i = 0; i < len; i++)
                  send_item(uabf_pkg::OP_PUSH, 8'($urandom),
                            (i == len - 1) || ($urandom_range(0, 9) == 0));
               counted += len;
               len = $urandom_range(0, 12);
               repeat (len) send_item(uabf_pkg::OP_PULL, 8'($urandom), 1'($urandom));
               counted += len;
            end else if (pick < 76) begin
               send_item(uabf_pkg::OP_FLUSH, 8'($urandom), 1'($urandom));
               counted++;
            end else if (pick < 86) begin
               send_item(OpUnused, 8'($urandom), 1'($urandom));
            end else begin
               send_item(2'($urandom_range(0, 2)), 8'($urandom), 1'($urandom));
               counted++;
            end
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_extremes();
      test_start_threshold();
      test_calm_stream();
      test_backpressure();
      test_random_mix();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
